// ===== src/tsq_pkg.sv =====
// Package for the touch sample qualifier: payload and configuration types,
// register index codes, reset values and the calibration and scaling constants.
// No dependencies.
package tsq_pkg;

  // Screen and calibration
  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 320;
  localparam int RAW_X_MIN     = 540;
  localparam int RAW_X_MAX     = 3756;
  localparam int RAW_Y_MIN     = 400;
  localparam int RAW_Y_MAX     = 3829;
  localparam int RAW_MARGIN    = 100;

  // Scaling datapath widths (screen sizes up to 512)
  localparam int RAW_W   = 12;
  localparam int PT_W    = 9;
  localparam int NUM_W   = 24;  // offset times (size - 1)
  localparam int EST_W   = 13;  // quotient before clamping
  localparam int K_W     = 25;  // reciprocal constant
  localparam int SHIFT   = 24;  // reciprocal scale
  localparam int PROD_W  = RAW_W + K_W;

  // Divisors and reciprocals: column comes from raw Y, row from raw X
  localparam int DIV_X = RAW_Y_MAX - RAW_Y_MIN;
  localparam int DIV_Y = RAW_X_MAX - RAW_X_MIN;
  localparam longint unsigned K_X_L =
    (longint'(SCREEN_WIDTH - 1) << SHIFT) / DIV_X;
  localparam longint unsigned K_Y_L =
    (longint'(SCREEN_HEIGHT - 1) << SHIFT) / DIV_Y;
  localparam logic [K_W-1:0] K_X = K_X_L[K_W-1:0];
  localparam logic [K_W-1:0] K_Y = K_Y_L[K_W-1:0];

  typedef struct packed {
    logic             irq_line;
    logic             touched;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic            pressed;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
  } result_t;

  typedef struct packed {
    logic [11:0] press_pressure;
    logic [11:0] hold_pressure;
    logic [2:0]  press_confirm_count;
    logic [2:0]  move_confirm_count;
    logic [2:0]  release_count;
    logic [8:0]  confirm_window;
    logic [8:0]  move_window;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_PRESS_PRESSURE      = 3'd0,
    CFG_HOLD_PRESSURE       = 3'd1,
    CFG_PRESS_CONFIRM_COUNT = 3'd2,
    CFG_MOVE_CONFIRM_COUNT  = 3'd3,
    CFG_RELEASE_COUNT       = 3'd4,
    CFG_CONFIRM_WINDOW      = 3'd5,
    CFG_MOVE_WINDOW         = 3'd6
  } cfg_index_t;

  localparam cfg_t CFG_RESET = '{
    press_pressure:      12'd380,
    hold_pressure:       12'd180,
    press_confirm_count: 3'd2,
    move_confirm_count:  3'd2,
    release_count:       3'd1,
    confirm_window:      9'd18,
    move_window:         9'd40
  };

  // Mapped sample handed from the scaling stage to the tracker
  typedef struct packed {
    logic             irq_line;
    logic             touched;
    logic             in_range;
    logic [RAW_W-1:0] raw_z;
    logic [PT_W-1:0]  point_x;
    logic [PT_W-1:0]  point_y;
  } mapped_t;

endpackage

// ===== src/tsq_map.sv =====
// Scaling stage: window check and calibrated mapping of raw X/Y to a screen
// point by reciprocal multiply, one-step correction and clamp. Uses tsq_pkg.
module tsq_map (
  input  logic             clk,
  input  logic             en,
  input  tsq_pkg::sample_t item,
  output tsq_pkg::mapped_t mapped
);

  localparam logic [tsq_pkg::RAW_W-1:0] X_LO =
    tsq_pkg::RAW_W'(tsq_pkg::RAW_X_MIN - tsq_pkg::RAW_MARGIN);
  localparam logic [tsq_pkg::RAW_W-1:0] X_HI =
    tsq_pkg::RAW_W'(tsq_pkg::RAW_X_MAX + tsq_pkg::RAW_MARGIN);
  localparam logic [tsq_pkg::RAW_W-1:0] Y_LO =
    tsq_pkg::RAW_W'(tsq_pkg::RAW_Y_MIN - tsq_pkg::RAW_MARGIN);
  localparam logic [tsq_pkg::RAW_W-1:0] Y_HI =
    tsq_pkg::RAW_W'(tsq_pkg::RAW_Y_MAX + tsq_pkg::RAW_MARGIN);
  localparam logic [tsq_pkg::RAW_W-1:0] X_MIN = tsq_pkg::RAW_W'(tsq_pkg::RAW_X_MIN);
  localparam logic [tsq_pkg::RAW_W-1:0] Y_MIN = tsq_pkg::RAW_W'(tsq_pkg::RAW_Y_MIN);
  localparam logic [tsq_pkg::NUM_W-1:0] DX = tsq_pkg::NUM_W'(tsq_pkg::DIV_X);
  localparam logic [tsq_pkg::NUM_W-1:0] DY = tsq_pkg::NUM_W'(tsq_pkg::DIV_Y);
  localparam logic [tsq_pkg::EST_W-1:0] MAX_X = tsq_pkg::EST_W'(tsq_pkg::SCREEN_WIDTH - 1);
  localparam logic [tsq_pkg::EST_W-1:0] MAX_Y = tsq_pkg::EST_W'(tsq_pkg::SCREEN_HEIGHT - 1);

  logic [tsq_pkg::RAW_W-1:0]  off_x, off_y;
  logic [tsq_pkg::PROD_W-1:0] prod_x, prod_y;
  logic [tsq_pkg::NUM_W-1:0]  num_x_d, num_y_d;

  logic                       irq_line, touched, in_range;
  logic [tsq_pkg::RAW_W-1:0]  raw_z;
  logic [tsq_pkg::NUM_W-1:0]  num_x, num_y;
  logic [tsq_pkg::EST_W-1:0]  est_x, est_y;

  logic [tsq_pkg::NUM_W-1:0]  rem_x, rem_y;
  logic [tsq_pkg::EST_W-1:0]  q_x, q_y, c_x, c_y;

  // Raw values below the calibrated minimum give a zero offset
  always_comb begin
    off_x   = (item.raw_y >= Y_MIN) ? item.raw_y - Y_MIN : '0;
    off_y   = (item.raw_x >= X_MIN) ? item.raw_x - X_MIN : '0;
    prod_x  = tsq_pkg::PROD_W'(off_x) * tsq_pkg::PROD_W'(tsq_pkg::K_X);
    prod_y  = tsq_pkg::PROD_W'(off_y) * tsq_pkg::PROD_W'(tsq_pkg::K_Y);
    num_x_d = tsq_pkg::NUM_W'(off_x) * tsq_pkg::NUM_W'(tsq_pkg::SCREEN_WIDTH - 1);
    num_y_d = tsq_pkg::NUM_W'(off_y) * tsq_pkg::NUM_W'(tsq_pkg::SCREEN_HEIGHT - 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      irq_line   <= item.irq_line;
      touched    <= item.touched;
      raw_z      <= item.raw_z;
      in_range   <= (item.raw_x >= X_LO) && (item.raw_x <= X_HI) &&
                    (item.raw_y >= Y_LO) && (item.raw_y <= Y_HI);
      num_x      <= num_x_d;
      num_y      <= num_y_d;
      est_x      <= prod_x[tsq_pkg::SHIFT +: tsq_pkg::EST_W];
      est_y      <= prod_y[tsq_pkg::SHIFT +: tsq_pkg::EST_W];
    end
  end

  // Estimate is the quotient or one short of it: fix up, then clamp
  always_comb begin
    rem_x = num_x - tsq_pkg::NUM_W'(est_x) * DX;
    rem_y = num_y - tsq_pkg::NUM_W'(est_y) * DY;
    q_x   = est_x + tsq_pkg::EST_W'(rem_x >= DX);
    q_y   = est_y + tsq_pkg::EST_W'(rem_y >= DY);
    c_x   = (q_x > MAX_X) ? MAX_X : q_x;
    c_y   = (q_y > MAX_Y) ? MAX_Y : q_y;
    mapped.irq_line   = irq_line;
    mapped.touched    = touched;
    mapped.in_range   = in_range;
    mapped.raw_z      = raw_z;
    mapped.point_x    = c_x[tsq_pkg::PT_W-1:0];
    mapped.point_y    = c_y[tsq_pkg::PT_W-1:0];
  end

endmodule

// ===== src/tsq_track.sv =====
// Tracker: pressure hysteresis, press/move confirmation and release delay,
// holding the touch state and forming each result. Uses tsq_pkg.
module tsq_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  tsq_pkg::cfg_t    cfg,
  input  tsq_pkg::mapped_t mapped,
  output tsq_pkg::result_t res
);

  logic                     confirmed, confirmed_next;
  logic [2:0]               press_streak, press_streak_next;
  logic [2:0]               release_streak, release_streak_next;
  logic [2:0]               move_streak, move_streak_next;
  logic [tsq_pkg::PT_W-1:0] committed_x, committed_x_next;
  logic [tsq_pkg::PT_W-1:0] committed_y, committed_y_next;
  logic [tsq_pkg::PT_W-1:0] candidate_x, candidate_x_next;
  logic [tsq_pkg::PT_W-1:0] candidate_y, candidate_y_next;

  function automatic logic near_point(input logic [8:0] ax, input logic [8:0] ay,
                                      input logic [8:0] bx, input logic [8:0] by,
                                      input logic [8:0] win);
    logic [8:0] dx;
    logic [8:0] dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return (dx <= win) && (dy <= win);
  endfunction

  always_comb begin
    logic [11:0] thr;
    logic [2:0]  streak;
    logic        invalid;
    logic        commit;
    logic [8:0]  x;
    logic [8:0]  y;

    confirmed_next      = confirmed;
    press_streak_next   = press_streak;
    release_streak_next = release_streak;
    move_streak_next    = move_streak;
    committed_x_next    = committed_x;
    committed_y_next    = committed_y;
    candidate_x_next    = candidate_x;
    candidate_y_next    = candidate_y;
    res.pressed = 1'b0;
    res.point_x = committed_x;
    res.point_y = committed_y;
    invalid = 1'b0;
    commit  = 1'b0;
    streak  = '0;
    x       = mapped.point_x;
    y       = mapped.point_y;
    thr     = confirmed ? cfg.hold_pressure : cfg.press_pressure;

    if (!mapped.irq_line) begin
      invalid = 1'b1;
    end else if (!confirmed && !mapped.touched) begin
      confirmed_next      = 1'b0;
      press_streak_next   = '0;
      release_streak_next = '0;
      move_streak_next    = '0;
    end else if (!mapped.in_range || mapped.raw_z < thr) begin
      invalid = 1'b1;
    end else begin
      release_streak_next = '0;
      if (!confirmed) begin
        streak = press_streak;
        if (press_streak == 3'd0 || near_point(x, y, candidate_x, candidate_y,
                                                cfg.confirm_window)) begin
          if (streak < cfg.press_confirm_count) streak = streak + 3'd1;
        end else begin
          streak = 3'd1;
        end
        press_streak_next = streak;
        candidate_x_next  = x;
        candidate_y_next  = y;
        if (streak >= cfg.press_confirm_count) begin
          confirmed_next = 1'b1;
          commit         = 1'b1;
        end
      end else if (!near_point(x, y, committed_x, committed_y, cfg.move_window)) begin
        streak = move_streak;
        if (move_streak == 3'd0 || near_point(x, y, candidate_x, candidate_y,
                                               cfg.confirm_window)) begin
          if (streak < cfg.move_confirm_count) streak = streak + 3'd1;
        end else begin
          streak = 3'd1;
        end
        move_streak_next = streak;
        candidate_x_next = x;
        candidate_y_next = y;
        // Hold the committed point until the move is confirmed
        res.pressed = 1'b1;
        if (streak >= cfg.move_confirm_count) commit = 1'b1;
      end else begin
        commit = 1'b1;
      end
    end

    if (invalid) begin
      if (confirmed && ({1'b0, release_streak} + 4'd1 < {1'b0, cfg.release_count})) begin
        release_streak_next = release_streak + 3'd1;
        res.pressed         = 1'b1;
      end else begin
        confirmed_next      = 1'b0;
        press_streak_next   = '0;
        release_streak_next = '0;
        move_streak_next    = '0;
      end
    end

    if (commit) begin
      committed_x_next = x;
      committed_y_next = y;
      move_streak_next = '0;
      res.pressed      = 1'b1;
      res.point_x      = x;
      res.point_y      = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      confirmed      <= 1'b0;
      press_streak   <= '0;
      release_streak <= '0;
      move_streak    <= '0;
      committed_x    <= '0;
      committed_y    <= '0;
      candidate_x    <= '0;
      candidate_y    <= '0;
    end else if (en) begin
      confirmed      <= confirmed_next;
      press_streak   <= press_streak_next;
      release_streak <= release_streak_next;
      move_streak    <= move_streak_next;
      committed_x    <= committed_x_next;
      committed_y    <= committed_y_next;
      candidate_x    <= candidate_x_next;
      candidate_y    <= candidate_y_next;
    end
  end

endmodule

// ===== src/touch_sample_qualifier_unit.sv =====
// Top level of the touch sample qualifier: handshakes, configuration
// registers and the three-stage pipeline. Uses tsq_pkg, tsq_map, tsq_track.
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_ready    tsq_pkg::sample_t
//   result    out        result_valid / result_ready    tsq_pkg::result_t
//   cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// One sample per cycle while results are taken. Each accepted request passes
// through the input register on the accepting edge, then the scaling register,
// then the result register.
// rst is synchronous: it empties the pipeline, clears the touch state and
// loads the register defaults. A stalled result stalls the whole pipeline in
// step, so sample_ready falls only while a result waits and is not taken.
module touch_sample_qualifier_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  tsq_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output tsq_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [11:0]      cfg_data
);

  logic             advance;
  logic             s1_valid, s2_valid;
  tsq_pkg::sample_t s1_item;
  tsq_pkg::mapped_t mapped;
  tsq_pkg::result_t res_next;
  tsq_pkg::cfg_t    cfg;

  // Advance every stage together whenever the result slot is free or taken
  assign advance      = !result_valid || result_ready;
  assign sample_ready = advance;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tsq_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tsq_pkg::CFG_PRESS_PRESSURE:      cfg.press_pressure      <= cfg_data;
        tsq_pkg::CFG_HOLD_PRESSURE:       cfg.hold_pressure       <= cfg_data;
        tsq_pkg::CFG_PRESS_CONFIRM_COUNT: cfg.press_confirm_count <= cfg_data[2:0];
        tsq_pkg::CFG_MOVE_CONFIRM_COUNT:  cfg.move_confirm_count  <= cfg_data[2:0];
        tsq_pkg::CFG_RELEASE_COUNT:       cfg.release_count       <= cfg_data[2:0];
        tsq_pkg::CFG_CONFIRM_WINDOW:      cfg.confirm_window      <= cfg_data[8:0];
        tsq_pkg::CFG_MOVE_WINDOW:         cfg.move_window         <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= sample_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  // Input register: hold the accepted request
  always_ff @(posedge clk) begin
    if (advance && sample_valid) s1_item <= sample;
  end

  // Scaling stage: window check and calibrated mapping
  tsq_map u_map (
    .clk    (clk),
    .en     (advance && s1_valid),
    .item   (s1_item),
    .mapped (mapped)
  );

  // Tracking stage: touch state updates as the result is registered
  tsq_track u_track (
    .clk    (clk),
    .rst    (rst),
    .en     (advance && s2_valid),
    .cfg    (cfg),
    .mapped (mapped),
    .res    (res_next)
  );

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (advance && s2_valid) result <= res_next;
  end

endmodule

// ===== tb/touch_sample_qualifier_checker.sv =====
`timescale 1ns / 100ps
// Checker for touch_sample_qualifier_unit: watches the sample, result and register
// channels, predicts each report from its own copy of the touch state and compares.
// Depends on tsq_pkg only.
module touch_sample_qualifier_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             sample_ready,
  input  tsq_pkg::sample_t sample,
  input  logic             result_valid,
  input  logic             result_ready,
  input  tsq_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [11:0]      cfg_data,
  output int               mismatches,
  output int               reports_due,
  output int               samples_seen,
  output int               reports_seen,
  output int               presses_seen
);

  tsq_pkg::cfg_t    settings;
  logic             held;
  logic [2:0]       press_run, release_run, move_run;
  logic [8:0]       commit_x, commit_y, cand_x, cand_y;
  tsq_pkg::result_t pending_reports[$];
  tsq_pkg::result_t want;

  function automatic tsq_pkg::result_t report(input logic p, input logic [8:0] x,
                                              input logic [8:0] y);
    tsq_pkg::result_t r;
    r.pressed = p;
    r.point_x = x;
    r.point_y = y;
    return r;
  endfunction

  function automatic logic [8:0] scale_axis(input int raw, input int lo, input int hi,
                                            input int size);
    int v;
    v = ((raw - lo) * (size - 1)) / (hi - lo);
    if (v < 0) v = 0;
    if (v > size - 1) v = size - 1;
    return v[8:0];
  endfunction

  function automatic bit close_to(input logic [8:0] ax, input logic [8:0] ay,
                                  input logic [8:0] bx, input logic [8:0] by,
                                  input logic [8:0] win);
    logic [8:0] dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return (dx <= win) && (dy <= win);
  endfunction

  function automatic void clear_touch();
    press_run   = '0;
    release_run = '0;
    move_run    = '0;
    held        = 1'b0;
  endfunction

  // Invalid sample: hold the press while the release streak allows it
  function automatic tsq_pkg::result_t miss_sample();
    if (held && (int'(release_run) + 1 < int'(settings.release_count))) begin
      release_run = release_run + 3'd1;
      return report(1'b1, commit_x, commit_y);
    end
    clear_touch();
    return report(1'b0, commit_x, commit_y);
  endfunction

  function automatic tsq_pkg::result_t qualify(input tsq_pkg::sample_t s);
    logic [11:0] level;
    bit          window_ok;
    logic [8:0]  col, row;
    if (!s.irq_line) return miss_sample();
    if (!held && !s.touched) begin
      clear_touch();
      return report(1'b0, commit_x, commit_y);
    end
    level = held ? settings.hold_pressure : settings.press_pressure;
    window_ok = int'(s.raw_x) >= tsq_pkg::RAW_X_MIN - tsq_pkg::RAW_MARGIN &&
                int'(s.raw_x) <= tsq_pkg::RAW_X_MAX + tsq_pkg::RAW_MARGIN &&
                int'(s.raw_y) >= tsq_pkg::RAW_Y_MIN - tsq_pkg::RAW_MARGIN &&
                int'(s.raw_y) <= tsq_pkg::RAW_Y_MAX + tsq_pkg::RAW_MARGIN;
    if (!window_ok || s.raw_z < level) return miss_sample();
    release_run = '0;
    // axes are swapped: column from raw Y, row from raw X
    col = scale_axis(int'(s.raw_y), tsq_pkg::RAW_Y_MIN, tsq_pkg::RAW_Y_MAX,
                     tsq_pkg::SCREEN_WIDTH);
    row = scale_axis(int'(s.raw_x), tsq_pkg::RAW_X_MIN, tsq_pkg::RAW_X_MAX,
                     tsq_pkg::SCREEN_HEIGHT);
    if (!held) begin
      if (press_run == 0 || close_to(col, row, cand_x, cand_y, settings.confirm_window)) begin
        if (press_run < settings.press_confirm_count) press_run = press_run + 3'd1;
      end else begin
        press_run = 3'd1;
      end
      cand_x = col;
      cand_y = row;
      if (press_run < settings.press_confirm_count) return report(1'b0, commit_x, commit_y);
      held = 1'b1;
    end else if (!close_to(col, row, commit_x, commit_y, settings.move_window)) begin
      if (move_run == 0 || close_to(col, row, cand_x, cand_y, settings.confirm_window)) begin
        if (move_run < settings.move_confirm_count) move_run = move_run + 3'd1;
      end else begin
        move_run = 3'd1;
      end
      cand_x = col;
      cand_y = row;
      if (move_run < settings.move_confirm_count) return report(1'b1, commit_x, commit_y);
    end
    commit_x = col;
    commit_y = row;
    move_run = '0;
    return report(1'b1, col, row);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings = tsq_pkg::CFG_RESET;
      clear_touch();
      commit_x = '0;
      commit_y = '0;
      cand_x   = '0;
      cand_y   = '0;
      pending_reports.delete();
    end else begin
      if (cfg_we) begin
        case (tsq_pkg::cfg_index_t'(cfg_index))
          tsq_pkg::CFG_PRESS_PRESSURE:      settings.press_pressure      = cfg_data;
          tsq_pkg::CFG_HOLD_PRESSURE:       settings.hold_pressure       = cfg_data;
          tsq_pkg::CFG_PRESS_CONFIRM_COUNT: settings.press_confirm_count = cfg_data[2:0];
          tsq_pkg::CFG_MOVE_CONFIRM_COUNT:  settings.move_confirm_count  = cfg_data[2:0];
          tsq_pkg::CFG_RELEASE_COUNT:       settings.release_count       = cfg_data[2:0];
          tsq_pkg::CFG_CONFIRM_WINDOW:      settings.confirm_window      = cfg_data[8:0];
          tsq_pkg::CFG_MOVE_WINDOW:         settings.move_window         = cfg_data[8:0];
          default: ;
        endcase
      end
      if (sample_valid && sample_ready) begin
        pending_reports.push_back(qualify(sample));
        samples_seen++;
      end
      if (result_valid && result_ready) begin
        reports_seen++;
        if (result.pressed === 1'b1) presses_seen++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected report: pressed=%0b x=%0d y=%0d", $realtime,
                     result.pressed, result.point_x, result.point_y);
        end else begin
          want = pending_reports.pop_front();
          if (result.pressed !== want.pressed || result.point_x !== want.point_x ||
              result.point_y !== want.point_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] report %0d: want p=%0b x=%0d y=%0d, got p=%0b x=%0d y=%0d",
                       $realtime, reports_seen, want.pressed, want.point_x, want.point_y,
                       result.pressed, result.point_x, result.point_y);
          end
        end
      end
    end
    reports_due = pending_reports.size();
  end

endmodule

// ===== tb/touch_sample_qualifier_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for touch_sample_qualifier_unit: clock, reset, sample requests,
// register settings, handshake idling and the verdict.
// Depends on tsq_pkg, touch_sample_qualifier_unit and touch_sample_qualifier_checker.
module touch_sample_qualifier_unit_tb;

  // Cycles with no request or report moving before the run is abandoned;
  // well above the long result hold-off below.
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_OFF       = 300;
  localparam int PHASE_REQUESTS = 194;
  localparam int PHASES         = 8;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_ready;
  tsq_pkg::sample_t sample_in    = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  tsq_pkg::result_t result_out;
  logic             cfg_we       = 1'b0;
  logic [2:0]       cfg_index    = '0;
  logic [11:0]      cfg_data     = '0;

  int mismatches, reports_due, samples_seen, reports_seen, presses_seen;

  // Idling knobs, percent of cycles; changed only just after a rising edge
  int            tx_pct     = 0;
  int            rx_pct     = 0;
  bit            hold_req   = 1'b0;
  int            hold_left  = 0;
  tsq_pkg::cfg_t active_cfg = tsq_pkg::CFG_RESET;

  always #6 clk = ~clk;

  touch_sample_qualifier_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  touch_sample_qualifier_checker qualifier_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .reports_due  (reports_due),
    .samples_seen (samples_seen),
    .reports_seen (reports_seen),
    .presses_seen (presses_seen)
  );

  // Report receiver: a pending hold-off request wins, otherwise stall at
  // random by the current percentage. One assignment per falling edge.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_OFF;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  // Watchdog: abandon the run once nothing has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_valid && sample_ready) || (result_valid && result_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] no progress for %0d cycles, %0d reports outstanding",
             $realtime, STALL_LIMIT, reports_due);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic tsq_pkg::sample_t touch_at(input bit irq, input bit tch, input int x,
                                                input int y, input int z);
    tsq_pkg::sample_t s;
    s.irq_line   = irq;
    s.touched    = tch;
    s.raw_x      = x[11:0];
    s.raw_y      = y[11:0];
    s.raw_z      = z[11:0];
    return s;
  endfunction

  function automatic logic [11:0] clamp12(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  // Favour pressures around the two thresholds so hysteresis gets exercised
  function automatic logic [11:0] pick_pressure();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 12'($urandom_range(active_cfg.press_pressure, 4095));
    if (r < 8)
      return 12'($urandom_range(active_cfg.hold_pressure, active_cfg.press_pressure));
    return 12'($urandom_range(0, 4095));
  endfunction

  // Offer one request: idle first as the sender pattern says, then hold
  // valid and payload until the request is taken. Returns on a falling edge.
  task automatic offer(input tsq_pkg::sample_t s);
    int idle;
    idle = 0;
    while (idle < 20 && $urandom_range(0, 99) < tx_pct) idle++;
    if (idle > 0) begin
      sample_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_in    <= s;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected report is back, plus the
  // pipeline depth, so the block is idle for register writes.
  task automatic settle();
    sample_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input tsq_pkg::cfg_index_t idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Write every register; write enable stays high across the burst
  task automatic write_settings(input tsq_pkg::cfg_t c);
    write_reg(tsq_pkg::CFG_PRESS_PRESSURE,      c.press_pressure);
    write_reg(tsq_pkg::CFG_HOLD_PRESSURE,       c.hold_pressure);
    write_reg(tsq_pkg::CFG_PRESS_CONFIRM_COUNT, {9'd0, c.press_confirm_count});
    write_reg(tsq_pkg::CFG_MOVE_CONFIRM_COUNT,  {9'd0, c.move_confirm_count});
    write_reg(tsq_pkg::CFG_RELEASE_COUNT,       {9'd0, c.release_count});
    write_reg(tsq_pkg::CFG_CONFIRM_WINDOW,      {3'd0, c.confirm_window});
    write_reg(tsq_pkg::CFG_MOVE_WINDOW,         {3'd0, c.move_window});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random traffic: mostly strokes (touch down, jitter, occasional jumps,
  // brief dropouts), some lift-off runs and some pure noise.
  task automatic run_traffic(input int count);
    int               sent, kind, len, jitter, bx, by;
    tsq_pkg::sample_t s;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        s.irq_line   = 1'($urandom);
        s.touched    = 1'($urandom);
        s.raw_x      = 12'($urandom);
        s.raw_y      = 12'($urandom);
        s.raw_z      = 12'($urandom);
        offer(s);
        sent++;
      end else if (kind >= 8) begin
        len = $urandom_range(1, 9);
        for (int k = 0; k < len && sent < count; k++) begin
          s.irq_line   = 1'($urandom_range(0, 1));
          s.touched    = 1'($urandom);
          s.raw_x      = 12'($urandom);
          s.raw_y      = 12'($urandom);
          s.raw_z      = 12'($urandom_range(0, active_cfg.hold_pressure));
          offer(s);
          sent++;
        end
      end else begin
        bx     = $urandom_range(400, 3900);
        by     = $urandom_range(260, 3970);
        jitter = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
        len    = $urandom_range(2, 24);
        for (int k = 0; k < len && sent < count; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            bx = $urandom_range(400, 3900);
            by = $urandom_range(260, 3970);
          end
          s.irq_line   = ($urandom_range(0, 19) != 0);
          s.touched    = ($urandom_range(0, 11) != 0);
          s.raw_x      = clamp12(bx + int'($urandom_range(0, 2 * jitter)) - jitter);
          s.raw_y      = clamp12(by + int'($urandom_range(0, 2 * jitter)) - jitter);
          s.raw_z      = pick_pressure();
          offer(s);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values
    offer(touch_at(0, 0, 0, 0, 0));               // interrupt low while idle
    offer(touch_at(1, 0, 2000, 2000, 4095));      // touched flag low before a press
    offer(touch_at(1, 1, 0, 0, 4095));            // far outside the window
    offer(touch_at(1, 1, 4095, 4095, 4095));
    offer(touch_at(1, 1, 439, 2000, 4095));       // one step past each window edge
    offer(touch_at(1, 1, 2000, 299, 4095));
    offer(touch_at(1, 1, 3857, 2000, 4095));
    offer(touch_at(1, 1, 2000, 3930, 4095));
    offer(touch_at(1, 1, 2000, 2000, 379));       // just under the press level
    offer(touch_at(1, 1, 440, 300, 380));         // window corner, clamps to origin
    offer(touch_at(1, 1, 440, 300, 380));         // second nearby sample confirms
    offer(touch_at(1, 1, 3856, 3929, 4095));      // large move, held at old point
    offer(touch_at(1, 1, 3856, 3929, 4095));      // move accepted, clamps to far corner
    offer(touch_at(1, 0, 3800, 3900, 180));       // touched ignored once confirmed
    offer(touch_at(1, 1, 3800, 3900, 179));       // below hold level: release
    offer(touch_at(1, 1, 2000, 2000, 500));
    offer(touch_at(1, 1, 2100, 2050, 500));       // nearby: confirm
    offer(touch_at(1, 1, 2100, 2050, 4095));
    offer(touch_at(0, 1, 2100, 2050, 4095));      // interrupt drops: release
    offer(touch_at(1, 1, 1000, 1000, 1000));
    offer(touch_at(1, 1, 3000, 3000, 1000));      // not near candidate: restart streak
    offer(touch_at(1, 1, 3010, 3000, 1000));      // confirm
    offer(touch_at(1, 1, 1000, 1000, 1000));      // large move pending
    offer(touch_at(1, 1, 3000, 1000, 1000));      // inconsistent move: streak back to one
    offer(touch_at(1, 1, 3000, 1010, 1000));      // consistent: move accepted
    offer(touch_at(0, 0, 4095, 4095, 4095));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      // Field order: press, hold, press count, move count, release, confirm win, move win
      case (p)
        0: active_cfg = tsq_pkg::CFG_RESET;
        1: active_cfg = '{12'd0, 12'd0, 3'd0, 3'd0, 3'd0, 9'd0, 9'd0};
        2: active_cfg = '{12'd4095, 12'd4095, 3'd7, 3'd7, 3'd7, 9'd511, 9'd511};
        3: active_cfg = '{12'd300, 12'd500, 3'd1, 3'd3, 3'd3, 9'd5, 9'd20};
        5: active_cfg = '{12'd1000, 12'd200, 3'd7, 3'd1, 3'd0, 9'd511, 9'd0};
        7: active_cfg = '{12'd380, 12'd180, 3'd2, 3'd2, 3'd7, 9'd18, 9'd40};
        default: begin
          active_cfg.press_pressure      = 12'($urandom_range(0, 4095));
          active_cfg.hold_pressure       = 12'($urandom_range(0, 4095));
          active_cfg.press_confirm_count = 3'($urandom_range(0, 7));
          active_cfg.move_confirm_count  = 3'($urandom_range(0, 7));
          active_cfg.release_count       = 3'($urandom_range(0, 7));
          active_cfg.confirm_window      = 9'($urandom_range(0, 511));
          active_cfg.move_window         = 9'($urandom_range(0, 511));
        end
      endcase
      write_settings(active_cfg);

      // Cycle through the idling patterns: none, sender, receiver, both
      @(posedge clk);
      tx_pct   = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 27 : 0;
      rx_pct   = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 27 : 0;
      hold_req = (p == 0);  // long receiver hold-off fills the pipeline
      @(negedge clk);

      if (p == 3) begin
        // Pause the sender mid-phase until every report is back
        run_traffic(PHASE_REQUESTS / 2);
        settle();
        run_traffic(PHASE_REQUESTS - PHASE_REQUESTS / 2);
      end else begin
        run_traffic(PHASE_REQUESTS);
      end
    end

    // Drain, then allow the pipeline depth and some slack for strays
    sample_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Covered %0d sample requests and %0d reports (%0d pressed): directed edges,",
             samples_seen, reports_seen, presses_seen);
    $display("  %0d register settings incl. extremes, four idling patterns, hold-off and drain.",
             PHASES);
    if (mismatches == 0 && reports_due == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== touch_sample_qualifier_unit.f =====
src/tsq_pkg.sv
src/tsq_map.sv
src/tsq_track.sv
src/touch_sample_qualifier_unit.sv
tb/touch_sample_qualifier_checker.sv
tb/touch_sample_qualifier_unit_tb.sv
